/* hdl/nearest_sphere_ray_pick_top_defines.svh */
// Assertion macros shared by the ray pick RTL.
`ifndef NEAREST_SPHERE_RAY_PICK_TOP_DEFINES_SVH
`define NEAREST_SPHERE_RAY_PICK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NSRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/nsrp_pkg.sv */
// Types, constants and helpers for the ray pick block.
package nsrp_pkg;

   localparam int MAX_SPHERES = 16;
   localparam int IDX_W = $clog2(MAX_SPHERES);

   localparam int MUL_W = 34;
   localparam int PROD_W = 2 * MUL_W;

   // 1000.0 in Q16.16
   localparam logic [31:0] FAR_LIMIT = 32'd65536000;
   localparam logic signed [35:0] FAR_POS = 36'sd65536000;
   localparam logic signed [35:0] FAR_NEG = -36'sd65536000;

   localparam logic signed [39:0] I32_MAX = 40'sh007FFFFFFF;
   localparam logic signed [39:0] I32_MIN = -40'sh0080000000;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_CHECK,
      ST_ROOT1,
      ST_STEP,
      ST_ROOT2,
      ST_FINISH
   } state_type;

   // what the multiplier was given last cycle
   typedef enum logic [2:0] {
      OP_NONE,
      OP_DOT,
      OP_LSQ,
      OP_RSQ,
      OP_TSQ,
      OP_STEP,
      OP_DSQ
   } op_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > I32_MAX) r = 32'sh7FFFFFFF;
      else if (v < I32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

/* hdl/nsrp_mul.sv */
// Shared signed multiplier with registered product.
module nsrp_mul (
   input  logic                                 clock,
   input  logic signed [nsrp_pkg::MUL_W-1:0]    a,
   input  logic signed [nsrp_pkg::MUL_W-1:0]    b,
   output logic signed [nsrp_pkg::PROD_W-1:0]   p
);

   logic signed [nsrp_pkg::PROD_W-1:0] p_ff;
   logic signed [nsrp_pkg::PROD_W-1:0] p_in;

   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

/* hdl/nsrp_sqrt.sv */
// Bit-serial integer square root, floor(sqrt(x)) of a 64-bit value in 32 steps.
module nsrp_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  nsrp_pkg::sqrt_req_type  req,
   output nsrp_pkg::sqrt_rsp_type  rsp
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.x;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = res_ff[31:0];

endmodule

/* hdl/nearest_sphere_ray_pick_top.sv */
// Top level of the ray pick block: sequencer, register file and result register.
//
// Picks the nearest sphere hit by a configured ray, one sphere per input transfer, in signed
// Q16.16. A sphere with radius zero or less goes straight to finish; otherwise one shared 34x34
// multiplier runs the dot product, squares and step products, and a ray that does not miss the
// sphere runs a one-bit-per-cycle square root unit, once for the hit offset and, for a hit in
// front within range, again for the distance. req_tready is high only between spheres. The sphere
// with req_tlast set sends one result and clears the best hit; the next sphere is accepted while
// that result waits for rsp_tready.
module nearest_sphere_ray_pick_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // center_x, center_y, center_z, radius, sphere_index, zero pad
   input  logic [135:0]  req_tdata,
   input  logic          req_tlast,       // last_sphere
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // hit_index, hit_x, hit_y, hit_z, zero pad
   output logic [103:0]  rsp_tdata,
   output logic          rsp_tuser,       // hit_found
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int IW = nsrp_pkg::IDX_W;

   nsrp_pkg::state_type state_ff, state_in;
   nsrp_pkg::op_type    op_ff, op_in;
   logic [1:0]          lane_ff, lane_in;
   logic [3:0]          cnt_ff, cnt_in;

   logic signed [31:0] org_ff [3];
   logic signed [17:0] dir_ff [3];

   logic signed [31:0] l_ff [3];
   logic signed [31:0] l_in [3];
   logic signed [31:0] r_ff, r_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               last_ff, last_in;
   logic signed [51:0] dot_ff, dot_in;
   logic signed [31:0] tm_ff, tm_in;
   logic [48:0]        lsq_ff, lsq_in;
   logic [45:0]        r2_ff, r2_in;
   logic [46:0]        tsq_ff, tsq_in;
   logic signed [33:0] t_ff, t_in;
   logic signed [35:0] step_ff [3];
   logic signed [35:0] step_in [3];
   logic               far_ff, far_in;
   logic [37:0]        dsq_ff, dsq_in;

   logic [31:0]        best_dist_ff, best_dist_in;
   logic               best_found_ff, best_found_in;
   logic [IW-1:0]      best_index_ff, best_index_in;
   logic signed [31:0] best_pt_ff [3];
   logic signed [31:0] best_pt_in [3];

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [IW-1:0]      rsp_index_ff, rsp_index_in;
   logic signed [31:0] rsp_pt_ff [3];
   logic signed [31:0] rsp_pt_in [3];

   logic signed [nsrp_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [nsrp_pkg::PROD_W-1:0] mul_p;
   nsrp_pkg::sqrt_req_type             sq_req;
   nsrp_pkg::sqrt_rsp_type             sq_rsp;

   logic signed [31:0] cin [3];
   logic signed [31:0] rad_in;
   logic signed [51:0] dot_sum;
   logic signed [35:0] step_new;
   logic signed [49:0] dval;
   logic signed [49:0] slack;
   logic signed [33:0] t_a, t_b, t_sel;
   logic               req_fire;

   assign cin[0] = req_tdata[31:0];
   assign cin[1] = req_tdata[63:32];
   assign cin[2] = req_tdata[95:64];
   assign rad_in = req_tdata[127:96];

   assign req_tready = (state_ff == nsrp_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   nsrp_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   nsrp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .rsp   (sq_rsp)
   );

   // sequencer: next state and multiplier / square root issue
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = nsrp_pkg::OP_NONE;
      lane_in   = 2'd0;
      mul_a     = '0;
      mul_b     = '0;
      sq_req.start = 1'b0;
      sq_req.x     = '0;
      dval  = $signed({1'b0, lsq_ff}) - $signed({3'b000, tsq_ff});
      slack = $signed({4'b0000, r2_ff}) - dval;
      t_a   = $signed({{2{tm_ff[31]}}, tm_ff}) - $signed({2'b00, sq_rsp.root});
      t_b   = $signed({{2{tm_ff[31]}}, tm_ff}) + $signed({2'b00, sq_rsp.root});
      t_sel = t_a[33] ? t_b : t_a;
      case (state_ff)
         nsrp_pkg::ST_IDLE: begin
            if (req_fire) begin
               cnt_in   = '0;
               state_in = (rad_in > 32'sd0) ? nsrp_pkg::ST_PROD : nsrp_pkg::ST_FINISH;
            end
         end
         nsrp_pkg::ST_PROD: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff < 4'd3) begin
               mul_a   = {{2{l_ff[cnt_ff[1:0]][31]}}, l_ff[cnt_ff[1:0]]};
               mul_b   = {{16{dir_ff[cnt_ff[1:0]][17]}}, dir_ff[cnt_ff[1:0]]};
               op_in   = nsrp_pkg::OP_DOT;
               lane_in = cnt_ff[1:0];
            end else if (cnt_ff < 4'd6) begin
               lane_in = 2'(cnt_ff - 4'd3);
               mul_a   = {{2{l_ff[lane_in][31]}}, l_ff[lane_in]};
               mul_b   = mul_a;
               op_in   = nsrp_pkg::OP_LSQ;
            end else if (cnt_ff == 4'd6) begin
               mul_a = {{2{r_ff[31]}}, r_ff};
               mul_b = mul_a;
               op_in = nsrp_pkg::OP_RSQ;
            end else if (cnt_ff == 4'd7) begin
               mul_a = {{2{tm_ff[31]}}, tm_ff};
               mul_b = mul_a;
               op_in = nsrp_pkg::OP_TSQ;
            end else begin
               state_in = nsrp_pkg::ST_CHECK;
            end
         end
         nsrp_pkg::ST_CHECK: begin
            if (dval > $signed({4'b0000, r2_ff})) begin
               state_in = nsrp_pkg::ST_FINISH;
            end else begin
               sq_req.start = 1'b1;
               sq_req.x     = {slack[47:0], 16'h0000};
               state_in     = nsrp_pkg::ST_ROOT1;
            end
         end
         nsrp_pkg::ST_ROOT1: begin
            if (sq_rsp.done) begin
               cnt_in = '0;
               if (t_sel[33] || (t_sel == '0)) state_in = nsrp_pkg::ST_FINISH;
               else state_in = nsrp_pkg::ST_STEP;
            end
         end
         nsrp_pkg::ST_STEP: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff < 4'd3) begin
               mul_a   = t_ff;
               mul_b   = {{16{dir_ff[cnt_ff[1:0]][17]}}, dir_ff[cnt_ff[1:0]]};
               op_in   = nsrp_pkg::OP_STEP;
               lane_in = cnt_ff[1:0];
            end else if (cnt_ff < 4'd6) begin
               lane_in = 2'(cnt_ff - 4'd3);
               mul_a   = step_ff[lane_in][33:0];
               mul_b   = mul_a;
               op_in   = nsrp_pkg::OP_DSQ;
            end else if (cnt_ff == 4'd7) begin
               if (far_ff) begin
                  state_in = nsrp_pkg::ST_FINISH;
               end else begin
                  sq_req.start = 1'b1;
                  sq_req.x     = {10'd0, dsq_ff, 16'h0000};
                  state_in     = nsrp_pkg::ST_ROOT2;
               end
            end
         end
         nsrp_pkg::ST_ROOT2: begin
            if (sq_rsp.done) state_in = nsrp_pkg::ST_FINISH;
         end
         nsrp_pkg::ST_FINISH: begin
            if (!last_ff || !rsp_valid_ff || rsp_tready) state_in = nsrp_pkg::ST_IDLE;
         end
         default: state_in = nsrp_pkg::ST_IDLE;
      endcase
   end

   // datapath: operand capture, product accumulation, best hit and result register
   always_comb begin
      l_in    = l_ff;
      r_in    = r_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      dot_in  = dot_ff;
      tm_in   = tm_ff;
      lsq_in  = lsq_ff;
      r2_in   = r2_ff;
      tsq_in  = tsq_ff;
      t_in    = t_ff;
      step_in = step_ff;
      far_in  = far_ff;
      dsq_in  = dsq_ff;
      best_dist_in  = best_dist_ff;
      best_found_in = best_found_ff;
      best_index_in = best_index_ff;
      best_pt_in    = best_pt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_pt_in     = rsp_pt_ff;
      dot_sum  = dot_ff + mul_p[51:0];
      step_new = mul_p[51:16];

      if (req_fire) begin
         for (int i = 0; i < 3; i++) begin
            l_in[i] = nsrp_pkg::sat32({{8{cin[i][31]}}, cin[i]}
                                     - {{8{org_ff[i][31]}}, org_ff[i]});
         end
         r_in    = rad_in;
         idx_in  = req_tdata[128 +: IW];
         last_in = req_tlast;
         dot_in  = '0;
         lsq_in  = '0;
         dsq_in  = '0;
         far_in  = 1'b0;
      end

      case (op_ff)
         nsrp_pkg::OP_DOT: begin
            dot_in = dot_sum;
            if (lane_ff == 2'd2) tm_in = nsrp_pkg::sat32({{4{dot_sum[51]}}, dot_sum[51:16]});
         end
         nsrp_pkg::OP_LSQ: lsq_in = lsq_ff + {2'b00, mul_p[62:16]};
         nsrp_pkg::OP_RSQ: r2_in  = mul_p[61:16];
         nsrp_pkg::OP_TSQ: tsq_in = mul_p[62:16];
         nsrp_pkg::OP_STEP: begin
            step_in[lane_ff] = step_new;
            if (step_new >= nsrp_pkg::FAR_POS || step_new <= nsrp_pkg::FAR_NEG) far_in = 1'b1;
         end
         nsrp_pkg::OP_DSQ: dsq_in = dsq_ff + {2'b00, mul_p[51:16]};
         default: begin
         end
      endcase

      if (state_ff == nsrp_pkg::ST_ROOT1 && sq_rsp.done) t_in = t_sel;

      if (state_ff == nsrp_pkg::ST_ROOT2 && sq_rsp.done && sq_rsp.root < best_dist_ff) begin
         best_dist_in  = sq_rsp.root;
         best_found_in = 1'b1;
         best_index_in = idx_ff;
         for (int i = 0; i < 3; i++) begin
            best_pt_in[i] = nsrp_pkg::sat32({{4{step_ff[i][35]}}, step_ff[i]}
                                           + {{8{org_ff[i][31]}}, org_ff[i]});
         end
      end

      // best index and point are zero when nothing was hit, so they are sent as is
      if (state_ff == nsrp_pkg::ST_FINISH && last_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = best_found_ff;
         rsp_index_in  = best_index_ff;
         rsp_pt_in     = best_pt_ff;
         best_dist_in  = nsrp_pkg::FAR_LIMIT;
         best_found_in = 1'b0;
         best_index_in = '0;
         for (int i = 0; i < 3; i++) best_pt_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nsrp_pkg::ST_IDLE;
         op_ff         <= nsrp_pkg::OP_NONE;
         lane_ff       <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         best_dist_ff  <= nsrp_pkg::FAR_LIMIT;
         best_found_ff <= 1'b0;
         best_index_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            best_pt_ff[i] <= '0;
            org_ff[i]     <= '0;
         end
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= -18'sd65536;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         lane_ff       <= lane_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_dist_ff  <= best_dist_in;
         best_found_ff <= best_found_in;
         best_index_ff <= best_index_in;
         best_pt_ff    <= best_pt_in;
         if (csr_valid) begin
            case (nsrp_pkg::csr_index_type'(csr_index))
               nsrp_pkg::CSR_ORIGIN_X: org_ff[0] <= csr_data;
               nsrp_pkg::CSR_ORIGIN_Y: org_ff[1] <= csr_data;
               nsrp_pkg::CSR_ORIGIN_Z: org_ff[2] <= csr_data;
               nsrp_pkg::CSR_DIR_X:    dir_ff[0] <= csr_data[17:0];
               nsrp_pkg::CSR_DIR_Y:    dir_ff[1] <= csr_data[17:0];
               nsrp_pkg::CSR_DIR_Z:    dir_ff[2] <= csr_data[17:0];
               default: begin
               end
            endcase
         end
      end
      l_ff    <= l_in;
      r_ff    <= r_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      dot_ff  <= dot_in;
      tm_ff   <= tm_in;
      lsq_ff  <= lsq_in;
      r2_ff   <= r2_in;
      tsq_ff  <= tsq_in;
      t_ff    <= t_in;
      step_ff <= step_in;
      far_ff  <= far_in;
      dsq_ff  <= dsq_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pt_ff    <= rsp_pt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {4'b0000, rsp_pt_ff[2], rsp_pt_ff[1], rsp_pt_ff[0], rsp_index_ff};

`include "nearest_sphere_ray_pick_top_defines.svh"

   `NSRP_ASSERT_IMP(a_best_limit, clock, reset, 1'b1, best_dist_ff <= nsrp_pkg::FAR_LIMIT, "best distance above limit")
   `NSRP_ASSERT_IMP(a_nohit_clear, clock, reset, !best_found_ff, best_index_ff == '0 && best_pt_ff[0] == '0 && best_dist_ff == nsrp_pkg::FAR_LIMIT, "best state not clear without hit")
   `NSRP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, state_ff != nsrp_pkg::ST_IDLE, "sequencer idle after sphere transfer")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the nearest sphere ray pick block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam longint FAR_Q = 64'sd65536000;

   typedef struct {
      logic signed [31:0] cx, cy, cz, rad;
      logic [3:0]         idx;
      logic               last;
   } sphere_type;

   typedef struct {
      logic               found;
      logic [3:0]         idx;
      logic signed [31:0] px, py, pz;
   } pick_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   nearest_sphere_ray_pick_top dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // ray configuration and best-hit tracker
   longint org[3];
   longint dirv[3];
   longint best_dist;
   logic best_found;
   logic [3:0] best_idx;
   longint best_pt[3];

   pick_type picks_due[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned res = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void clear_best();
      best_dist = FAR_Q;
      best_found = 0;
      best_idx = 0;
      best_pt = '{0, 0, 0};
   endfunction

   function automatic void try_sphere(sphere_type s);
      longint c[3], lv[3], stp[3];
      longint dot, tm, lsq, tsq, r2, d, th, t, r;
      longint unsigned dsq, u;
      c[0] = s.cx; c[1] = s.cy; c[2] = s.cz;
      r = s.rad;
      dot = 0; lsq = 0; dsq = 0;
      for (int i = 0; i < 3; i++) begin
         lv[i] = sat32(c[i] - org[i]);
         dot += lv[i] * dirv[i];
         lsq += (lv[i] * lv[i]) >>> 16;
      end
      tm = sat32(dot >>> 16);
      tsq = (tm * tm) >>> 16;
      r2 = (r * r) >>> 16;
      d = lsq - tsq;
      if (d > r2) return;
      u = r2 - d;
      th = root64(u << 16);
      t = tm - th;
      if (t < 0) t = tm + th;
      if (t <= 0) return;
      for (int i = 0; i < 3; i++) begin
         stp[i] = (t * dirv[i]) >>> 16;
         if (stp[i] >= FAR_Q || stp[i] <= -FAR_Q) return;
         dsq += longint'((stp[i] * stp[i]) >>> 16);
      end
      t = root64(dsq << 16);
      if (t >= best_dist) return;   // ties keep the earlier hit
      best_dist = t;
      best_found = 1;
      best_idx = s.idx;
      for (int i = 0; i < 3; i++) best_pt[i] = sat32(org[i] + stp[i]);
   endfunction

   function automatic void predict_pick(sphere_type s);
      pick_type p;
      if (s.rad > 0) try_sphere(s);
      if (s.last) begin
         p.found = best_found;
         p.idx = best_found ? best_idx : 4'd0;
         p.px = best_found ? best_pt[0][31:0] : 32'd0;
         p.py = best_found ? best_pt[1][31:0] : 32'd0;
         p.pz = best_found ? best_pt[2][31:0] : 32'd0;
         picks_due = {picks_due, p};
         clear_best();
      end
   endfunction

   // receiver: random stalls plus long hold-offs
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pick_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (picks_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            e = picks_due.pop_front();
            if (rsp_tuser !== e.found || rsp_tdata[3:0] !== e.idx ||
                rsp_tdata[35:4] !== e.px || rsp_tdata[67:36] !== e.py ||
                rsp_tdata[99:68] !== e.pz) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp f=%0d i=%0d p=(%h %h %h) got f=%0d i=%0d p=(%h %h %h)",
                     e.found, e.idx, e.px, e.py, e.pz, rsp_tuser, rsp_tdata[3:0],
                     rsp_tdata[35:4], rsp_tdata[67:36], rsp_tdata[99:68]);
            end
         end
      end
   end

   task automatic send_sphere(sphere_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, s.idx, s.rad, s.cz, s.cy, s.cx};
      req_tlast <= s.last;
      do @(posedge clock); while (!req_tready);
      predict_pick(s);
   endtask

   task automatic stop_sending();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // settle: every result in, then let the block go quiet
   task automatic drain();
      stop_sending();
      while (picks_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         nsrp_pkg::CSR_ORIGIN_X: org[0] = longint'($signed(val));
         nsrp_pkg::CSR_ORIGIN_Y: org[1] = longint'($signed(val));
         nsrp_pkg::CSR_ORIGIN_Z: org[2] = longint'($signed(val));
         nsrp_pkg::CSR_DIR_X: dirv[0] = longint'($signed(val[17:0]));
         nsrp_pkg::CSR_DIR_Y: dirv[1] = longint'($signed(val[17:0]));
         nsrp_pkg::CSR_DIR_Z: dirv[2] = longint'($signed(val[17:0]));
         default: ;
      endcase
   endtask

   task automatic set_ray(logic [31:0] ox, oy, oz, logic [17:0] dx, dy, dz);
      write_reg(nsrp_pkg::CSR_ORIGIN_X, ox);
      write_reg(nsrp_pkg::CSR_ORIGIN_Y, oy);
      write_reg(nsrp_pkg::CSR_ORIGIN_Z, oz);
      write_reg(nsrp_pkg::CSR_DIR_X, {{14{dx[17]}}, dx});
      write_reg(nsrp_pkg::CSR_DIR_Y, {{14{dy[17]}}, dy});
      write_reg(nsrp_pkg::CSR_DIR_Z, {{14{dz[17]}}, dz});
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic sphere_type mk(longint x, y, z, r, int idx, bit last);
      sphere_type s;
      s.cx = 32'(x); s.cy = 32'(y); s.cz = 32'(z); s.rad = 32'(r);
      s.idx = 4'(idx); s.last = last;
      return s;
   endfunction

   // mostly spheres placed near the ray, some pure noise
   function automatic sphere_type rand_sphere(bit last);
      sphere_type s;
      longint t, r;
      if ($urandom_range(99) < 15) begin
         s = mk($signed($urandom), $signed($urandom), $signed($urandom),
                $signed($urandom), $urandom_range(15), last);
      end else begin
         t = longint'($urandom_range(1200)) * 65536 + $urandom_range(65535);
         r = $urandom_range(30 * 65536) + 1;
         s = mk(sat32(org[0] + ((t * dirv[0]) >>> 16) + longint'($signed($urandom)) % r),
                sat32(org[1] + ((t * dirv[1]) >>> 16) + longint'($signed($urandom)) % r),
                sat32(org[2] + ((t * dirv[2]) >>> 16) + longint'($signed($urandom)) % r),
                r, $urandom_range(15), last);
         if ($urandom_range(99) < 8) s.rad = 32'(-longint'($urandom_range(65536)));
         if ($urandom_range(99) < 3) s.rad = 0;
      end
      return s;
   endfunction

   task automatic random_picks(int n);
      int left = n;
      int len;
      while (left > 0) begin
         len = $urandom_range(6, 1);
         for (int k = 0; k < len && left > 0; k++, left--)
            send_sphere(rand_sphere(k == len - 1 || left == 1));
      end
   endtask

   task automatic test_directed();
      // reset ray: origin 0, looking down -z
      send_sphere(mk(0, 0, -10 * 65536, 65536, 3, 1));
      send_sphere(mk(0, 0, -5 * 65536, 0, 1, 0));            // zero radius
      send_sphere(mk(0, 0, -5 * 65536, -65536, 2, 1));       // negative radius, last
      send_sphere(mk(0, 0, 10 * 65536, 65536, 4, 1));        // behind the origin
      send_sphere(mk(0, 0, -20 * 65536, 2 * 65536, 5, 0));   // equal distance:
      send_sphere(mk(0, 0, -20 * 65536, 2 * 65536, 6, 1));   // first one wins
      send_sphere(mk(0, 0, -2000 * 65536, 65536, 7, 1));     // beyond 1000.0
      send_sphere(mk(0, 0, 0, 3 * 65536, 15, 1));            // origin inside
      send_sphere(mk(0, 0, -30 * 65536, 65536, 8, 0));
      send_sphere(mk(0, 0, -9 * 65536, 65536, 0, 1));        // nearer replaces
      send_sphere(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 15, 1));
      send_sphere(mk(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                     32'sh7FFFFFFF, 0, 1));
      send_sphere(mk(0, 65536, -40 * 65536, 2 * 65536, 9, 1)); // off axis
      drain();
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      set_ray(32'h7FFFFFFF, 32'h80000000, 0, 18'sd65536, 18'sd0, 18'sd0);
      send_sphere(mk(32'h7FFFFFFF, 32'h80000000, 0, 5 * 65536, 10, 1));
      send_sphere(mk(32'h7FFF0000, 32'h80000000, 0, 65536, 11, 1));
      drain();
      set_ray(0, 0, 0, 18'sd65536, 18'sd65536, 18'sd65536);    // not unit length
      send_sphere(mk(50 * 65536, 50 * 65536, 50 * 65536, 4 * 65536, 12, 1));
      send_sphere(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 13, 1));
      drain();
   endtask

   task automatic test_ray_settings();
      set_ray(0, 0, 0, -18'sd65536, 18'sd0, 18'sd0);
      random_picks(40);
      drain();
      set_ray(-100 * 65536, 20 * 65536, 5 * 65536, 18'sd0, 18'sd39322, 18'sd52429);
      random_picks(40);
      drain();
      set_ray($urandom, $urandom, $urandom, 18'sd0, -18'sd65536, 18'sd0);
      random_picks(30);
      drain();
   endtask

   task automatic test_idling();
      set_ray(10 * 65536, -7 * 65536, 3 * 65536, 18'sd37837, -18'sd37837, 18'sd37837);
      send_idle_pct = 19; recv_idle_pct = 78;
      random_picks(230);
      drain();
      send_idle_pct = 78; recv_idle_pct = 19;
      random_picks(200);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      set_ray(0, 0, 0, 18'sd0, 18'sd0, 18'sd65536);
      random_picks(230);
      drain();
   endtask

   task automatic test_backpressure();
      // one-sphere picks while the receiver holds off: block fills and stalls
      hold_cycles = 600;
      for (int k = 0; k < 12; k++) send_sphere(rand_sphere(1));
      stop_sending();
      while (picks_due.size() != 0) @(posedge clock);
      random_picks(40);
      drain();
   endtask

   initial begin
      org = '{0, 0, 0};
      dirv = '{0, 0, -65536};
      clear_best();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_ray_settings();
      test_idling();
      test_backpressure();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/nsrp_pkg.sv
hdl/nsrp_mul.sv
hdl/nsrp_sqrt.sv
hdl/nearest_sphere_ray_pick_top.sv
tb/tb_top.sv
